// ===== src/bptm_pkg.sv =====
package bptm_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int ADDR_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_DELETE     = 2'd1,
    OP_SET_ENABLE = 2'd2,
    OP_MATCH      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_SET   = 3'd3,
    ST_HIT       = 3'd4,
    ST_STEP_TRAP = 3'd5,
    ST_NO_HIT    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_MATCH_SCAN
  } state_t;

  // Update request for the slot flag bits.
  typedef struct packed {
    logic             claim;
    logic             release_slot;
    logic             set_en;
    logic [IDX_W-1:0] idx;
    logic             tmp;
    logic             en;
  } flag_cmd_t;

  // Flag bits of one slot as read back.
  typedef struct packed {
    logic in_use;
    logic enabled;
    logic temporary;
  } flag_rd_t;

endpackage

// ===== src/bptm_addr_mem.sv =====
module bptm_addr_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bptm_pkg::IDX_W-1:0]  waddr,
  input  logic [bptm_pkg::ADDR_W-1:0] wdata,
  input  logic [bptm_pkg::IDX_W-1:0]  raddr,
  output logic [bptm_pkg::ADDR_W-1:0] rdata
);

  logic [bptm_pkg::ADDR_W-1:0] mem [bptm_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bptm_slot_flags.sv =====
module bptm_slot_flags (
  input  logic                       clk,
  input  logic                       rst,
  input  bptm_pkg::flag_cmd_t        cmd,
  input  logic [bptm_pkg::IDX_W-1:0] scan_idx,
  input  logic [bptm_pkg::IDX_W-1:0] edit_idx,
  output bptm_pkg::flag_rd_t         scan_rd,
  output bptm_pkg::flag_rd_t         edit_rd
);

  logic [bptm_pkg::NUM_SLOTS-1:0] in_use;
  logic [bptm_pkg::NUM_SLOTS-1:0] enabled;
  logic [bptm_pkg::NUM_SLOTS-1:0] temporary;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      enabled   <= '0;
      temporary <= '0;
    end else begin
      if (cmd.claim) begin
        in_use[cmd.idx]    <= 1'b1;
        enabled[cmd.idx]   <= 1'b1;
        temporary[cmd.idx] <= cmd.tmp;
      end
      if (cmd.release_slot) begin
        in_use[cmd.idx] <= 1'b0;
      end
      if (cmd.set_en) begin
        enabled[cmd.idx] <= cmd.en;
      end
    end
  end

  assign scan_rd = '{in_use: in_use[scan_idx], enabled: enabled[scan_idx],
                     temporary: temporary[scan_idx]};
  assign edit_rd = '{in_use: in_use[edit_idx], enabled: enabled[edit_idx],
                     temporary: temporary[edit_idx]};

endmodule

// ===== src/breakpoint_table_match.sv =====
// Breakpoint slot table with a shared address comparator.
//
// Command channel: an operation (opcode, address, slot, temporary,
// enable_value, step_trap) is taken at a rising edge with start high and
// busy low. Each transaction yields exactly one result on status,
// result_slot and hit_temporary, marked by done for one cycle; the
// receiver cannot stall, so the result must be taken in that cycle.
// Delete and set enable finish at once: done is high in the cycle after
// acceptance and busy never rises. Add scans the in-use bits one slot per
// cycle. Match reads one stored address per cycle from the address
// memory and compares it in the single comparator. busy falls in the
// cycle that done is high, so the next transaction can be taken right
// then. Reset clears the in-use, enabled and temporary bits at once and
// returns the sequencer to idle; stored addresses are not cleared, since
// a slot is never compared before add writes it.
module breakpoint_table_match (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [bptm_pkg::ADDR_W-1:0] address,
  input  logic [bptm_pkg::SLOT_W-1:0] slot,
  input  logic                        temporary,
  input  logic                        enable_value,
  input  logic                        step_trap,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [bptm_pkg::SLOT_W-1:0] result_slot,
  output logic                        hit_temporary
);

  localparam logic [bptm_pkg::IDX_W-1:0] LAST_IDX = bptm_pkg::IDX_W'(bptm_pkg::NUM_SLOTS - 1);

  bptm_pkg::state_t state, state_next;

  logic [bptm_pkg::IDX_W-1:0]  idx, idx_next;
  logic [bptm_pkg::IDX_W-1:0]  cmp_idx;
  logic                        cmp_valid, cmp_valid_next;
  logic                        rd_done, rd_done_next;
  logic [bptm_pkg::ADDR_W-1:0] op_addr;
  logic                        op_tmp;
  logic                        op_trap;
  logic                        accept;

  logic                        done_next;
  logic [2:0]                  status_next;
  logic [bptm_pkg::SLOT_W-1:0] result_slot_next;
  logic                        hit_temporary_next;

  bptm_pkg::flag_cmd_t         flag_cmd;
  bptm_pkg::flag_rd_t          scan_rd, edit_rd;
  logic [bptm_pkg::IDX_W-1:0]  scan_idx;
  logic                        mem_we;
  logic [bptm_pkg::ADDR_W-1:0] mem_rdata;
  logic                        slot_in_range;
  logic                        addr_equal;

  function automatic logic mem_mem_cmp(input logic [bptm_pkg::ADDR_W-1:0] a,
                                       input logic [bptm_pkg::ADDR_W-1:0] b);
    return a == b;
  endfunction

  assign accept        = start && !busy;
  assign busy          = (state != bptm_pkg::S_IDLE);
  assign slot_in_range = ({1'b0, slot} < (bptm_pkg::SLOT_W + 1)'(bptm_pkg::NUM_SLOTS));
  assign scan_idx      = (state == bptm_pkg::S_ADD_SCAN) ? idx : cmp_idx;
  assign addr_equal    = (mem_mem_cmp(mem_rdata, op_addr));

  bptm_slot_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .cmd      (flag_cmd),
    .scan_idx (scan_idx),
    .edit_idx (slot[bptm_pkg::IDX_W-1:0]),
    .scan_rd  (scan_rd),
    .edit_rd  (edit_rd)
  );

  bptm_addr_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (op_addr),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    cmp_valid_next     = 1'b0;
    rd_done_next       = rd_done;
    done_next          = 1'b0;
    status_next        = status;
    result_slot_next   = result_slot;
    hit_temporary_next = hit_temporary;
    flag_cmd           = '{claim: 1'b0, release_slot: 1'b0, set_en: 1'b0,
                           idx: slot[bptm_pkg::IDX_W-1:0], tmp: op_tmp,
                           en: enable_value};
    mem_we             = 1'b0;

    unique case (state)
      bptm_pkg::S_IDLE: begin
        if (accept) begin
          idx_next     = '0;
          rd_done_next = 1'b0;
          unique case (bptm_pkg::op_t'(opcode))
            bptm_pkg::OP_ADD: begin
              state_next = bptm_pkg::S_ADD_SCAN;
            end
            bptm_pkg::OP_MATCH: begin
              state_next = bptm_pkg::S_MATCH_SCAN;
            end
            bptm_pkg::OP_DELETE, bptm_pkg::OP_SET_ENABLE: begin
              done_next          = 1'b1;
              result_slot_next   = '0;
              hit_temporary_next = 1'b0;
              if (!slot_in_range) begin
                status_next = bptm_pkg::ST_RANGE;
              end else if (!edit_rd.in_use) begin
                status_next = bptm_pkg::ST_NOT_SET;
              end else begin
                status_next = bptm_pkg::ST_OK;
                if (bptm_pkg::op_t'(opcode) == bptm_pkg::OP_DELETE) begin
                  flag_cmd.release_slot = 1'b1;
                end else begin
                  flag_cmd.set_en = 1'b1;
                end
              end
            end
          endcase
        end
      end

      bptm_pkg::S_ADD_SCAN: begin
        flag_cmd.idx = idx;
        if (!scan_rd.in_use) begin
          flag_cmd.claim     = 1'b1;
          mem_we             = 1'b1;
          done_next          = 1'b1;
          status_next        = bptm_pkg::ST_OK;
          result_slot_next   = bptm_pkg::SLOT_W'(idx);
          hit_temporary_next = 1'b0;
          state_next         = bptm_pkg::S_IDLE;
        end else if (idx == LAST_IDX) begin
          done_next          = 1'b1;
          status_next        = bptm_pkg::ST_FULL;
          result_slot_next   = '0;
          hit_temporary_next = 1'b0;
          state_next         = bptm_pkg::S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      bptm_pkg::S_MATCH_SCAN: begin
        // Reads are issued one slot ahead of the compare, since the
        // address memory registers its read data.
        if (!rd_done) begin
          cmp_valid_next = 1'b1;
          if (idx == LAST_IDX) begin
            rd_done_next = 1'b1;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        if (cmp_valid && scan_rd.in_use && scan_rd.enabled && addr_equal) begin
          done_next          = 1'b1;
          status_next        = bptm_pkg::ST_HIT;
          result_slot_next   = bptm_pkg::SLOT_W'(cmp_idx);
          hit_temporary_next = scan_rd.temporary;
          cmp_valid_next     = 1'b0;
          state_next         = bptm_pkg::S_IDLE;
        end else if (cmp_valid && cmp_idx == LAST_IDX) begin
          done_next          = 1'b1;
          status_next        = op_trap ? bptm_pkg::ST_STEP_TRAP : bptm_pkg::ST_NO_HIT;
          result_slot_next   = '0;
          hit_temporary_next = 1'b0;
          cmp_valid_next     = 1'b0;
          state_next         = bptm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bptm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bptm_pkg::S_IDLE;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
      rd_done   <= 1'b0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      cmp_valid <= cmp_valid_next;
      rd_done   <= rd_done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    cmp_idx       <= idx;
    status        <= status_next;
    result_slot   <= result_slot_next;
    hit_temporary <= hit_temporary_next;
    if (accept) begin
      op_addr <= address;
      op_tmp  <= temporary;
      op_trap <= step_trap;
    end
  end

endmodule

// ===== src/bptm_checker.sv =====
module bptm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  opcode,
  input logic [bptm_pkg::ADDR_W-1:0] address,
  input logic [bptm_pkg::SLOT_W-1:0] slot,
  input logic                        temporary,
  input logic                        enable_value,
  input logic                        step_trap,
  input logic                        done,
  input logic [2:0]                  status,
  input logic [bptm_pkg::SLOT_W-1:0] result_slot,
  input logic                        hit_temporary
);

  // Every result carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 3'd7))
    else $error("result with undefined status code");

  // Only a hit reports a temporary bit.
  a_tmp_only_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status != bptm_pkg::ST_HIT) |-> !hit_temporary)
    else $error("hit_temporary set on a result that is not a hit");

  // Results other than a hit or OK carry slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != bptm_pkg::ST_HIT && status != bptm_pkg::ST_OK) |->
    (result_slot == '0))
    else $error("nonzero result_slot on a result without a slot");

  // Add and match scan the table, so they always occupy the block.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == bptm_pkg::OP_ADD || opcode == bptm_pkg::OP_MATCH))
    |=> (busy && !done))
    else $error("scan operation did not hold busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind breakpoint_table_match bptm_checker u_bptm_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct {
    bptm_pkg::status_t           status;
    logic [bptm_pkg::SLOT_W-1:0] slot_no;
    logic                        tmp;
  } bp_result_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [1:0]                  opcode;
  logic [bptm_pkg::ADDR_W-1:0] address;
  logic [bptm_pkg::SLOT_W-1:0] slot;
  logic                        temporary;
  logic                        enable_value;
  logic                        step_trap;
  logic                        done;
  logic [2:0]                  status;
  logic [bptm_pkg::SLOT_W-1:0] result_slot;
  logic                        hit_temporary;

  // Shadow copy of the breakpoint table.
  logic [bptm_pkg::ADDR_W-1:0] bp_addr [bptm_pkg::NUM_SLOTS];
  bit                          bp_in_use [bptm_pkg::NUM_SLOTS];
  bit                          bp_enabled [bptm_pkg::NUM_SLOTS];
  bit                          bp_temp [bptm_pkg::NUM_SLOTS];

  bp_result_t                  expected_results[$];
  logic [bptm_pkg::ADDR_W-1:0] bp_addr_pool [24];
  int                          error_count = 0;
  int                          idle_pct = 0;

  breakpoint_table_match u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .address      (address),
    .slot         (slot),
    .temporary    (temporary),
    .enable_value (enable_value),
    .step_trap    (step_trap),
    .done         (done),
    .status       (status),
    .result_slot  (result_slot),
    .hit_temporary(hit_temporary)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [bptm_pkg::SLOT_W-1:0] rand_slot();
    return bptm_pkg::SLOT_W'($urandom);
  endfunction

  function automatic bp_result_t predict_breakpoint_op(bptm_pkg::op_t op,
                                                       logic [bptm_pkg::ADDR_W-1:0] addr,
                                                       logic [bptm_pkg::SLOT_W-1:0] s,
                                                       logic tmp, logic en, logic trap);
    bp_result_t r;
    bit found;
    logic [bptm_pkg::SLOT_W-1:0] idx;
    r.status  = bptm_pkg::ST_OK;
    r.slot_no = '0;
    r.tmp     = 1'b0;
    found     = 1'b0;
    case (op)
      bptm_pkg::OP_ADD: begin
        r.status = bptm_pkg::ST_FULL;
        for (int i = 0; i < bptm_pkg::NUM_SLOTS; i++) begin
          if (!found && !bp_in_use[i]) begin
            found         = 1'b1;
            idx           = bptm_pkg::SLOT_W'(i);
            bp_in_use[i]  = 1'b1;
            bp_enabled[i] = 1'b1;
            bp_temp[i]    = tmp;
            bp_addr[i]    = addr;
            r.status      = bptm_pkg::ST_OK;
            r.slot_no     = idx;
          end
        end
      end
      bptm_pkg::OP_DELETE, bptm_pkg::OP_SET_ENABLE: begin
        if (s >= bptm_pkg::NUM_SLOTS) begin
          r.status = bptm_pkg::ST_RANGE;
        end else if (!bp_in_use[s]) begin
          r.status = bptm_pkg::ST_NOT_SET;
        end else if (op == bptm_pkg::OP_DELETE) begin
          bp_in_use[s] = 1'b0;
        end else begin
          bp_enabled[s] = en;
        end
      end
      default: begin
        r.status = trap ? bptm_pkg::ST_STEP_TRAP : bptm_pkg::ST_NO_HIT;
        for (int i = 0; i < bptm_pkg::NUM_SLOTS; i++) begin
          if (!found && bp_in_use[i] && bp_enabled[i] && bp_addr[i] == addr) begin
            found     = 1'b1;
            idx       = bptm_pkg::SLOT_W'(i);
            r.status  = bptm_pkg::ST_HIT;
            r.slot_no = idx;
            r.tmp     = bp_temp[i];
          end
        end
      end
    endcase
    return r;
  endfunction

  // Nearest slot in use at or after a random start; a random slot if none is in use.
  function automatic logic [bptm_pkg::SLOT_W-1:0] pick_used_slot();
    int base;
    int idx;
    base = $urandom_range(0, bptm_pkg::NUM_SLOTS - 1);
    pick_used_slot = bptm_pkg::SLOT_W'(base);
    for (int k = bptm_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
      idx = (base + k) % bptm_pkg::NUM_SLOTS;
      if (bp_in_use[idx]) pick_used_slot = bptm_pkg::SLOT_W'(idx);
    end
  endfunction

  // Start stays high after acceptance so that back-to-back transactions need
  // no extra assignment; an idle burst lowers it.
  task automatic issue_op(bptm_pkg::op_t op, logic [bptm_pkg::ADDR_W-1:0] addr,
                          logic [bptm_pkg::SLOT_W-1:0] s,
                          logic tmp, logic en, logic trap);
    start        <= 1'b1;
    opcode       <= op;
    address      <= addr;
    slot         <= s;
    temporary    <= tmp;
    enable_value <= en;
    step_trap    <= trap;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_breakpoint_op(op, addr, s, tmp, en, trap));
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    bp_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("status: result with no transaction pending, actual %0d", status);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status);
          error_count++;
        end
        if (result_slot !== exp_r.slot_no) begin
          $error("result_slot: expected %0d, actual %0d", exp_r.slot_no, result_slot);
          error_count++;
        end
        if (hit_temporary !== exp_r.tmp) begin
          $error("hit_temporary: expected %0d, actual %0d", exp_r.tmp, hit_temporary);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_table;
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd0, 1'b1, 1'b1, 1'b0);
    issue_op(bptm_pkg::OP_MATCH, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 1'b1);
    issue_op(bptm_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b1, 1'b1);
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'h0000_0000, 6'd63, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_add_match;
    issue_op(bptm_pkg::OP_ADD, 32'h0000_0000, 6'd63, 1'b0, 1'b1, 1'b1);
    issue_op(bptm_pkg::OP_ADD, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_ADD, 32'h0000_0000, 6'd21, 1'b1, 1'b0, 1'b1);
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd42, 1'b1, 1'b1, 1'b1);
    issue_op(bptm_pkg::OP_MATCH, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_MATCH, 32'h1234_5678, 6'd0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_enable_delete;
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0, 1'b1);
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b0);
    // Disabling the slot again still succeeds.
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'h0000_0000, 6'd2, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b1);
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'h0000_0000, 6'd0, 1'b0, 1'b1, 1'b0);
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_DELETE, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_ADD, 32'h0000_0005, 6'd0, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_DELETE, 32'h0000_0000, 6'd1, 1'b0, 1'b0, 1'b0);
    issue_op(bptm_pkg::OP_SET_ENABLE, 32'h0000_0000, 6'd1, 1'b0, 1'b1, 1'b0);
    issue_op(bptm_pkg::OP_DELETE, 32'h0000_0000, 6'd1, 1'b0, 1'b0, 1'b0);
  endtask

  // Fills the table past capacity, hits the last slot, then empties it again.
  task automatic test_table_full;
    for (int n = 0; n < bptm_pkg::NUM_SLOTS; n++)
      issue_op(bptm_pkg::OP_ADD, 32'h4000 + n * 4, rand_slot(), rand_bit(), rand_bit(),
               rand_bit());
    issue_op(bptm_pkg::OP_MATCH, bp_addr[bptm_pkg::NUM_SLOTS-1], rand_slot(), rand_bit(),
             rand_bit(), rand_bit());
    issue_op(bptm_pkg::OP_DELETE, $urandom, bptm_pkg::SLOT_W'(bptm_pkg::NUM_SLOTS - 1),
             rand_bit(), rand_bit(), rand_bit());
    issue_op(bptm_pkg::OP_ADD, 32'h0000_4000, rand_slot(), 1'b1, rand_bit(), rand_bit());
    issue_op(bptm_pkg::OP_ADD, 32'h0000_4004, rand_slot(), 1'b0, rand_bit(), rand_bit());
    for (int n = 0; n < bptm_pkg::NUM_SLOTS; n++)
      issue_op(bptm_pkg::OP_DELETE, $urandom, bptm_pkg::SLOT_W'(n), rand_bit(), rand_bit(),
               rand_bit());
    issue_op(bptm_pkg::OP_MATCH, 32'h0000_4000, rand_slot(), rand_bit(), rand_bit(), 1'b1);
  endtask

  // Operation mix and idle rate change every 50 transactions so the table
  // drifts between nearly empty and full.
  task automatic test_random_traffic(int count, bit with_idle);
    bptm_pkg::op_t               op;
    logic [bptm_pkg::ADDR_W-1:0] a;
    logic [bptm_pkg::SLOT_W-1:0] s;
    int                          add_w, del_w, en_w, match_w, pick;
    add_w = 1; del_w = 1; en_w = 1; match_w = 1;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        add_w   = $urandom_range(1, 6);
        del_w   = $urandom_range(1, 6);
        en_w    = $urandom_range(1, 3);
        match_w = $urandom_range(2, 8);
        idle_pct = (!with_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      pick = $urandom_range(0, add_w + del_w + en_w + match_w - 1);
      if (pick < add_w) op = bptm_pkg::OP_ADD;
      else if (pick < add_w + del_w) op = bptm_pkg::OP_DELETE;
      else if (pick < add_w + del_w + en_w) op = bptm_pkg::OP_SET_ENABLE;
      else op = bptm_pkg::OP_MATCH;

      a = ($urandom_range(0, 9) < 6) ? bp_addr_pool[$urandom_range(0, 23)] : $urandom;
      s = ($urandom_range(0, 3) != 0) ? pick_used_slot() : rand_slot();
      if (op == bptm_pkg::OP_MATCH && $urandom_range(0, 2) == 0 && bp_in_use[s]) a = bp_addr[s];
      issue_op(op, a, s, rand_bit(), rand_bit(), rand_bit());
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    opcode       <= bptm_pkg::OP_ADD;
    address      <= '0;
    slot         <= '0;
    temporary    <= 1'b0;
    enable_value <= 1'b0;
    step_trap    <= 1'b0;
    bp_addr_pool[0] = 32'h0000_0000;
    bp_addr_pool[1] = 32'hFFFF_FFFF;
    bp_addr_pool[2] = 32'h0000_4000;
    for (int i = 3; i < 24; i++) bp_addr_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_add_match();
    test_enable_delete();
    test_table_full();
    test_random_traffic(1000, 1'b1);
    test_random_traffic(150, 1'b0);

    start <= 1'b0;
    for (int w = 0; w < 10000 && expected_results.size() != 0; w++) @(posedge clk);
    repeat (bptm_pkg::NUM_SLOTS + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("status: %0d transactions never answered", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
